// File: hdl/bgh_pkg.sv
// Shared types, constants and register codes for the boost governor.
package bgh_pkg;

   // Width of the wrapping millisecond time base.
   localparam int TIME_BITS = 32;
   // Width of the hysteresis run counters.
   localparam int COUNT_BITS = 8;
   // Width used when comparing a counter with an 8-bit threshold register.
   localparam int CMP_BITS = (COUNT_BITS > 8) ? COUNT_BITS : 8;
   // Width of the boost limit in milliseconds (65535 s * 1000).
   localparam int LIMIT_BITS = 26;
   // Width used when comparing elapsed time with the boost limit.
   localparam int ELAPSED_BITS = (TIME_BITS > LIMIT_BITS) ? TIME_BITS : LIMIT_BITS;

   // Score arithmetic.
   localparam int RAW_BITS = 20;
   localparam int SCORE_BITS = 17;
   localparam int PEN_BITS = 17;
   localparam logic [SCORE_BITS-1:0] SCORE_MAX = 17'd102400;
   localparam logic [SCORE_BITS-1:0] PT_35 = 17'd35840;
   localparam logic [SCORE_BITS-1:0] PT_60 = 17'd61440;
   localparam logic [SCORE_BITS-1:0] PT_75 = 17'd76800;
   localparam logic [10:0] LOAD_90 = 11'd1440;
   localparam logic [10:0] LOAD_95 = 11'd1520;
   localparam logic [PEN_BITS-1:0] PEN_BASE = 17'd2048;
   localparam logic [PEN_BITS-1:0] PEN_STEP = 17'd96;
   localparam logic [PEN_BITS-1:0] PEN_CAP = 17'd15360;

   // Configuration register indexes.
   localparam logic [2:0] CSR_POLICY_MODE = 3'd0;
   localparam logic [2:0] CSR_ENTER_SAMPLES = 3'd1;
   localparam logic [2:0] CSR_EXIT_SAMPLES = 3'd2;
   localparam logic [2:0] CSR_STARVATION_GUARD = 3'd3;
   localparam logic [2:0] CSR_MAX_BOOST_SECONDS = 3'd4;
   localparam logic [2:0] CSR_COOLDOWN_MS = 3'd5;

   // Policy modes.
   localparam logic [1:0] MODE_DEFAULT = 2'd0;
   localparam logic [1:0] MODE_PERFORMANCE = 2'd3;

   // Priority codes.
   localparam logic [1:0] PRIO_NORMAL = 2'd0;
   localparam logic [1:0] PRIO_ABOVE = 2'd1;
   localparam logic [1:0] PRIO_HIGH = 2'd2;

   // Urgency codes.
   localparam logic [1:0] URG_LOW = 2'd0;
   localparam logic [1:0] URG_MEDIUM = 2'd1;
   localparam logic [1:0] URG_HIGH = 2'd2;
   localparam logic [1:0] URG_IMMEDIATE = 2'd3;

   // Reason codes.
   localparam logic [2:0] WHY_COMMITTED = 3'd0;
   localparam logic [2:0] WHY_DEFAULT_MODE = 3'd1;
   localparam logic [2:0] WHY_NOT_FLAGGED = 3'd2;
   localparam logic [2:0] WHY_COOLDOWN = 3'd3;
   localparam logic [2:0] WHY_PENDING = 3'd4;
   localparam logic [2:0] WHY_MAX_BOOST = 3'd5;

   // Score and band flags of one item.
   typedef struct packed {
      logic [SCORE_BITS-1:0] score;
      logic [1:0] urgency;
      logic ge35;
      logic ge60;
      logic ge75;
   } score_info_type;

   // Hysteresis state.
   typedef struct packed {
      logic elevated;
      logic [COUNT_BITS-1:0] enter_run;
      logic [COUNT_BITS-1:0] exit_run;
   } hyst_type;

endpackage

// File: hdl/boost_governor_with_hysteresis_unit.sv
// Boost governor top level: input register, decision logic, result register.
//
//   channel | ports                     | direction | transfer
//   --------+---------------------------+-----------+------------------------
//   req     | req_valid/req_ready + 10  | in        | one workload sample
//   rsp     | rsp_valid/rsp_ready + 6   | out       | one decision per sample
//   csr     | csr_we, csr_index, wdata  | in        | register write, no wait
//
// An item passes through the input register and then sits in the result
// register until taken; one item enters per cycle when rsp_ready is high.
// The governor state is updated at the same edge the result is registered,
// so the next item in the input register always sees it.
// Reset clears the valid flags and the governor state and loads the configuration defaults.
// A stalled result register holds its item and backs up the input register.
module boost_governor_with_hysteresis_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [10:0] req_demand,
   input  logic [10:0] req_contention,
   input  logic [10:0] req_stability,
   input  logic req_sustained_heavy,
   input  logic req_transient_spike,
   input  logic [10:0] req_confidence,
   input  logic req_wants_action,
   input  logic [10:0] req_system_load,
   input  logic [10:0] req_game_load,
   input  logic [31:0] req_now_ms,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [1:0] rsp_priority_res,
   output logic rsp_act,
   output logic [16:0] rsp_score,
   output logic [1:0] rsp_urgency,
   output logic [2:0] rsp_why,
   output logic [7:0] rsp_entry_progress,
   input  logic csr_we,
   input  logic [2:0] csr_index,
   input  logic [23:0] csr_wdata
);

   // Configuration registers.
   logic [1:0] policy_mode_ff;
   logic [7:0] enter_samples_ff;
   logic [7:0] exit_samples_ff;
   logic starvation_guard_ff;
   logic [bgh_pkg::LIMIT_BITS-1:0] boost_limit_ff;
   logic [23:0] cooldown_ms_ff;

   // Input register.
   logic s1_valid_ff;
   logic [10:0] demand_ff;
   logic [10:0] contention_ff;
   logic [10:0] stability_ff;
   logic sustained_heavy_ff;
   logic transient_spike_ff;
   logic [10:0] confidence_ff;
   logic wants_action_ff;
   logic [10:0] system_load_ff;
   logic [10:0] game_load_ff;
   logic [bgh_pkg::TIME_BITS-1:0] now_ff;

   // Governor state.
   bgh_pkg::hyst_type hyst_ff;
   bgh_pkg::hyst_type hyst_in;
   logic boosting_ff;
   logic boosting_in;
   logic cooling_ff;
   logic cooling_in;
   logic [bgh_pkg::TIME_BITS-1:0] boost_start_ff;
   logic [bgh_pkg::TIME_BITS-1:0] boost_start_in;
   logic [bgh_pkg::TIME_BITS-1:0] cooldown_end_ff;
   logic [bgh_pkg::TIME_BITS-1:0] cooldown_end_in;

   // Result register.
   logic rsp_valid_ff;
   logic [1:0] prio_ff;
   logic [1:0] prio_in;
   logic act_ff;
   logic act_in;
   logic [16:0] score_ff;
   logic [1:0] urgency_ff;
   logic [2:0] why_ff;
   logic [2:0] why_in;
   logic [7:0] progress_ff;

   logic advance;
   bgh_pkg::score_info_type info;
   bgh_pkg::hyst_type hyst_base;
   logic [bgh_pkg::TIME_BITS-1:0] cool_diff;
   logic cool_over;
   logic blocked;
   logic qualify;
   logic [bgh_pkg::TIME_BITS-1:0] elapsed;
   logic limit_hit;
   logic [1:0] band_prio;

   // One hysteresis update with a qualifying or non-qualifying sample.
   function automatic bgh_pkg::hyst_type hyst_step(
      input bgh_pkg::hyst_type h,
      input logic q,
      input logic [7:0] enter_thr,
      input logic [7:0] exit_thr
   );
      bgh_pkg::hyst_type r;
      logic [bgh_pkg::COUNT_BITS-1:0] bumped;
      r = h;
      if (!h.elevated) begin
         if (q) begin
            bumped = (&h.enter_run) ? h.enter_run : h.enter_run + 1'b1;
            r.exit_run = '0;
            if (bgh_pkg::CMP_BITS'(bumped) >= bgh_pkg::CMP_BITS'(enter_thr)) begin
               r.elevated = 1'b1;
               r.enter_run = '0;
            end else begin
               r.enter_run = bumped;
            end
         end else begin
            r.enter_run = '0;
         end
      end else begin
         if (!q) begin
            bumped = (&h.exit_run) ? h.exit_run : h.exit_run + 1'b1;
            r.enter_run = '0;
            if (bgh_pkg::CMP_BITS'(bumped) >= bgh_pkg::CMP_BITS'(exit_thr)) begin
               r.elevated = 1'b0;
               r.exit_run = '0;
            end else begin
               r.exit_run = bumped;
            end
         end else begin
            r.exit_run = '0;
         end
      end
      return r;
   endfunction

   // Handshake: the input register moves on when the result register is free.
   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // Configuration writes; the boost limit is kept in milliseconds.
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_mode_ff <= bgh_pkg::MODE_DEFAULT;
         enter_samples_ff <= 8'd3;
         exit_samples_ff <= 8'd5;
         starvation_guard_ff <= 1'b1;
         boost_limit_ff <= bgh_pkg::LIMIT_BITS'(30000);
         cooldown_ms_ff <= 24'd5000;
      end else if (csr_we) begin
         case (csr_index)
            bgh_pkg::CSR_POLICY_MODE: policy_mode_ff <= csr_wdata[1:0];
            bgh_pkg::CSR_ENTER_SAMPLES: enter_samples_ff <= csr_wdata[7:0];
            bgh_pkg::CSR_EXIT_SAMPLES: exit_samples_ff <= csr_wdata[7:0];
            bgh_pkg::CSR_STARVATION_GUARD: starvation_guard_ff <= csr_wdata[0];
            bgh_pkg::CSR_MAX_BOOST_SECONDS: begin
               boost_limit_ff <= bgh_pkg::LIMIT_BITS'(csr_wdata[15:0])
                                 * bgh_pkg::LIMIT_BITS'(1000);
            end
            bgh_pkg::CSR_COOLDOWN_MS: cooldown_ms_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         demand_ff <= req_demand;
         contention_ff <= req_contention;
         stability_ff <= req_stability;
         sustained_heavy_ff <= req_sustained_heavy;
         transient_spike_ff <= req_transient_spike;
         confidence_ff <= req_confidence;
         wants_action_ff <= req_wants_action;
         system_load_ff <= req_system_load;
         game_load_ff <= req_game_load;
         now_ff <= bgh_pkg::TIME_BITS'(req_now_ms);
      end
   end

   // Score of the item in the input register.
   bgh_score u_score (
      .demand(demand_ff),
      .contention(contention_ff),
      .stability(stability_ff),
      .sustained_heavy(sustained_heavy_ff),
      .transient_spike(transient_spike_ff),
      .confidence(confidence_ff),
      .system_load(system_load_ff),
      .info(info)
   );

   // Cooldown still runs while now - cooldown_end is negative.
   assign cool_diff = now_ff - cooldown_end_ff;
   assign cool_over = !cool_diff[bgh_pkg::TIME_BITS-1];
   assign blocked = cooling_ff && !cool_over;

   // A finished cooldown clears the hysteresis before the sample is used.
   assign hyst_base = (wants_action_ff && cooling_ff && cool_over) ? '0 : hyst_ff;
   assign qualify = wants_action_ff && !blocked && info.ge35;

   // Elapsed boost time; a session that starts now has zero elapsed.
   assign elapsed = boosting_ff ? (now_ff - boost_start_ff) : '0;
   assign limit_hit = bgh_pkg::ELAPSED_BITS'(elapsed)
                      >= bgh_pkg::ELAPSED_BITS'(boost_limit_ff);

   // Priority from the score bands, the overload test and the guard.
   always_comb begin
      if (!info.ge35) begin
         band_prio = bgh_pkg::PRIO_NORMAL;
      end else if (!info.ge60 || system_load_ff >= bgh_pkg::LOAD_95) begin
         band_prio = bgh_pkg::PRIO_ABOVE;
      end else if (info.ge75 && policy_mode_ff == bgh_pkg::MODE_PERFORMANCE
                   && !(starvation_guard_ff && game_load_ff > bgh_pkg::LOAD_90)) begin
         band_prio = bgh_pkg::PRIO_HIGH;
      end else begin
         band_prio = bgh_pkg::PRIO_ABOVE;
      end
   end

   // Decision and next governor state.
   always_comb begin
      hyst_in = hyst_ff;
      boosting_in = boosting_ff;
      cooling_in = cooling_ff;
      boost_start_in = boost_start_ff;
      cooldown_end_in = cooldown_end_ff;
      prio_in = bgh_pkg::PRIO_NORMAL;
      act_in = 1'b0;
      if (policy_mode_ff == bgh_pkg::MODE_DEFAULT) begin
         why_in = bgh_pkg::WHY_DEFAULT_MODE;
      end else begin
         hyst_in = hyst_step(hyst_base, qualify, enter_samples_ff, exit_samples_ff);
         if (!wants_action_ff) begin
            why_in = bgh_pkg::WHY_NOT_FLAGGED;
         end else if (blocked) begin
            why_in = bgh_pkg::WHY_COOLDOWN;
         end else begin
            if (cooling_ff) begin
               cooling_in = 1'b0;
               boosting_in = 1'b0;
            end
            if (!hyst_in.elevated) begin
               why_in = bgh_pkg::WHY_PENDING;
            end else begin
               // A session that was ended by the cooldown restarts here.
               if (!boosting_ff || cooling_ff) begin
                  boost_start_in = now_ff;
               end
               if (limit_hit && boosting_ff && !cooling_ff
                   || (boosting_ff == cooling_ff || !boosting_ff)
                      && boost_limit_ff == '0) begin
                  cooling_in = 1'b1;
                  boosting_in = 1'b0;
                  cooldown_end_in = now_ff + bgh_pkg::TIME_BITS'(cooldown_ms_ff);
                  hyst_in = '0;
                  why_in = bgh_pkg::WHY_MAX_BOOST;
               end else begin
                  boosting_in = 1'b1;
                  prio_in = band_prio;
                  act_in = 1'b1;
                  why_in = bgh_pkg::WHY_COMMITTED;
               end
            end
         end
      end
   end

   // Governor state commits as the result is registered.
   always_ff @(posedge clock) begin
      if (reset) begin
         hyst_ff <= '0;
         boosting_ff <= 1'b0;
         cooling_ff <= 1'b0;
         boost_start_ff <= '0;
         cooldown_end_ff <= '0;
      end else if (advance) begin
         hyst_ff <= hyst_in;
         boosting_ff <= boosting_in;
         cooling_ff <= cooling_in;
         boost_start_ff <= boost_start_in;
         cooldown_end_ff <= cooldown_end_in;
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         prio_ff <= prio_in;
         act_ff <= act_in;
         score_ff <= info.score;
         urgency_ff <= info.urgency;
         why_ff <= why_in;
         progress_ff <= 8'(hyst_in.enter_run);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_priority_res = prio_ff;
   assign rsp_act = act_ff;
   assign rsp_score = score_ff;
   assign rsp_urgency = urgency_ff;
   assign rsp_why = why_ff;
   assign rsp_entry_progress = progress_ff;

endmodule

// File: hdl/bgh_score.sv
// Weighted allocation score, overload penalty and urgency bands of one item.
module bgh_score (
   input  logic [10:0] demand,
   input  logic [10:0] contention,
   input  logic [10:0] stability,
   input  logic sustained_heavy,
   input  logic transient_spike,
   input  logic [10:0] confidence,
   input  logic [10:0] system_load,
   output bgh_pkg::score_info_type info
);

   logic [bgh_pkg::RAW_BITS-1:0] dem_term;
   logic [bgh_pkg::RAW_BITS-1:0] con_term;
   logic [bgh_pkg::RAW_BITS-1:0] conf_term;
   logic [bgh_pkg::RAW_BITS-1:0] stab_term;
   logic [bgh_pkg::RAW_BITS-1:0] spike_term;
   logic [bgh_pkg::PEN_BITS-1:0] pen_raw;
   logic [bgh_pkg::PEN_BITS-1:0] pen;
   logic signed [bgh_pkg::RAW_BITS-1:0] raw;
   logic [bgh_pkg::SCORE_BITS-1:0] score;

   // Constant-weight products; the sum wraps in two's complement.
   assign dem_term = bgh_pkg::RAW_BITS'(demand) * bgh_pkg::RAW_BITS'(60);
   assign con_term = bgh_pkg::RAW_BITS'(contention) * bgh_pkg::RAW_BITS'(15);
   assign conf_term = bgh_pkg::RAW_BITS'(confidence) * bgh_pkg::RAW_BITS'(15);
   assign spike_term = transient_spike ? bgh_pkg::RAW_BITS'(10240) : '0;

   // Stability counts for a heavy load, is ignored for a spike, and
   // otherwise rewards low stability (this term may be negative).
   always_comb begin
      if (sustained_heavy) begin
         stab_term = bgh_pkg::RAW_BITS'(stability) * bgh_pkg::RAW_BITS'(15);
      end else if (transient_spike) begin
         stab_term = '0;
      end else begin
         stab_term = (bgh_pkg::RAW_BITS'(1024) - bgh_pkg::RAW_BITS'(stability))
                     * bgh_pkg::RAW_BITS'(10);
      end
   end

   // Overload penalty: 2 points plus 1.5 per percent over 90, capped.
   assign pen_raw = (bgh_pkg::PEN_BITS'(system_load) - bgh_pkg::PEN_BITS'(bgh_pkg::LOAD_90))
                    * bgh_pkg::PEN_STEP + bgh_pkg::PEN_BASE;

   always_comb begin
      if (system_load < bgh_pkg::LOAD_90) begin
         pen = '0;
      end else if (pen_raw > bgh_pkg::PEN_CAP) begin
         pen = bgh_pkg::PEN_CAP;
      end else begin
         pen = pen_raw;
      end
   end

   assign raw = $signed(dem_term + con_term + stab_term + spike_term + conf_term
                        - bgh_pkg::RAW_BITS'(pen));

   // Clamp to the score range.
   always_comb begin
      if (raw < 0) begin
         score = '0;
      end else if (raw > $signed(bgh_pkg::RAW_BITS'(bgh_pkg::SCORE_MAX))) begin
         score = bgh_pkg::SCORE_MAX;
      end else begin
         score = bgh_pkg::SCORE_BITS'(raw);
      end
   end

   // Band flags and urgency.
   always_comb begin
      info.score = score;
      info.ge35 = (score >= bgh_pkg::PT_35);
      info.ge60 = (score >= bgh_pkg::PT_60);
      info.ge75 = (score >= bgh_pkg::PT_75);
      if (info.ge75) begin
         info.urgency = bgh_pkg::URG_IMMEDIATE;
      end else if (info.ge60) begin
         info.urgency = bgh_pkg::URG_HIGH;
      end else if (info.ge35) begin
         info.urgency = bgh_pkg::URG_MEDIUM;
      end else begin
         info.urgency = bgh_pkg::URG_LOW;
      end
   end

endmodule
